FILE: rtl/fjog_pkg.sv
// ----------------------------------------------------------------------------
// fjog_pkg: shared types and constants for the framed DC motor jog controller
// Holds the transaction payload structs, register indexes and reset values.
// ----------------------------------------------------------------------------
package fjog_pkg;

  // Byte that opens a command frame.
  localparam logic [7:0] START_BYTE = 8'hFF;

  // Register reset values.
  localparam logic [15:0] RST_TICK_THRESHOLD  = 16'd1000;
  localparam logic [7:0]  RST_CENTER_POSITION = 8'd19;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_TICK_THRESHOLD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_POSITION = 2'd1;

  // Input item kinds.
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Direction codes.
  localparam logic DIR_CCW = 1'b0;
  localparam logic DIR_CW  = 1'b1;

  // One input transaction.
  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] duty;
    logic       direction;
    logic       stopped;
  } out_t;

endpackage

FILE: rtl/framed_dc_motor_jog_controller.sv
// ----------------------------------------------------------------------------
// framed_dc_motor_jog_controller: serial-framed DC motor jog controller
// Parses command frames from serial bytes, drives duty and direction, and
// stops the motor after a timed run counted in timer ticks.
// ----------------------------------------------------------------------------
//  Channel  Ports                         Payload
//  input    in_valid  in_stall  in_data   mode, data_byte
//  result   out_valid out_stall out_data  duty, direction, stopped
//  config   cfg_wr_en cfg_index cfg_data  tick_threshold, center_position
//
//  Each accepted transaction's result is presented on the next cycle if no
//  older result waits; one transaction per cycle is sustained unless stalled.
//  Results pass through a two-entry output queue, so input stalls only when
//  both entries hold results that the receiver has not yet taken.
//  Reset is synchronous and restores register defaults and empties the queue.
// ----------------------------------------------------------------------------
module framed_dc_motor_jog_controller import fjog_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_data,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic       push, pop;
  out_t       result;
  out_t       slot0_r, slot1_r;
  logic [1:0] count_r;

  assign in_stall  = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot0_r;
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  fjog_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (push),
    .item      (in_data),
    .result    (result)
  );

  // Two-entry result queue; slot0 is the head.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: ;
      endcase
    end
    if (pop) begin
      slot0_r <= (count_r == 2'd2) ? slot1_r : result;
    end else if (push && (count_r == 2'd0)) begin
      slot0_r <= result;
    end
    if (push && !pop && (count_r == 2'd1)) begin
      slot1_r <= result;
    end
  end

`ifndef SYNTHESIS
  // The queue never holds more than two results.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue overfilled");

  // A transaction into an empty queue appears as a result in the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (count_r == 2'd0)) |=> out_valid)
    else $error("accepted transaction did not produce a result");

  // A stopped controller never drives the motor.
  a_stopped_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.stopped) |-> (out_data.duty == 8'd0))
    else $error("duty nonzero while stopped");

  // A result taken from a full queue with nothing new leaves one entry.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push && (count_r == 2'd2)) |=> (count_r == 2'd1))
    else $error("result queue count slipped");
`endif

endmodule

FILE: rtl/fjog_core.sv
// ----------------------------------------------------------------------------
// fjog_core: frame parser, interval timer and motor drive state
// Updates all controller state on each accepted transaction and presents the
// state after that update as the result.
// ----------------------------------------------------------------------------
module fjog_core import fjog_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   take,
  input  in_t                    item,
  output out_t                   result
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_STEPPER,
    PH_POSITION,
    PH_SPEED,
    PH_ESCAPE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_threshold_r;
  logic [7:0]  center_position_r;
  logic [7:0]  held_position_r, held_position_nxt;
  logic [7:0]  held_speed_r, held_speed_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [7:0]  intervals_done_r, intervals_done_nxt;
  logic [7:0]  intervals_target_r, intervals_target_nxt;
  logic        stop_r, stop_nxt;
  logic [7:0]  duty_r, duty_nxt;
  logic        dir_r, dir_nxt;
  logic [15:0] tick_inc;

  assign tick_inc = tick_count_r + 16'd1;

  // Next state for one transaction.
  always_comb begin
    phase_nxt            = phase_r;
    held_position_nxt    = held_position_r;
    held_speed_nxt       = held_speed_r;
    tick_count_nxt       = tick_count_r;
    intervals_done_nxt   = intervals_done_r;
    intervals_target_nxt = intervals_target_r;
    stop_nxt             = stop_r;
    duty_nxt             = duty_r;
    dir_nxt              = dir_r;

    if (item.mode == MODE_TICK) begin
      // Timer tick: count, and close an interval once past the threshold.
      tick_count_nxt = tick_inc;
      if (!stop_r && (tick_inc > tick_threshold_r)) begin
        tick_count_nxt = 16'd0;
        if (intervals_done_r < intervals_target_r) begin
          intervals_done_nxt = intervals_done_r + 8'd1;
        end else begin
          duty_nxt = 8'd0;
          stop_nxt = 1'b1;
        end
      end
    end else begin
      // Serial byte: walk the command frame.
      case (phase_r)
        PH_HUNT: begin
          if (item.data_byte == START_BYTE) phase_nxt = PH_STEPPER;
        end
        PH_STEPPER: begin
          phase_nxt = PH_POSITION;
        end
        PH_POSITION: begin
          held_position_nxt = item.data_byte;
          phase_nxt         = PH_SPEED;
        end
        PH_SPEED: begin
          held_speed_nxt = item.data_byte;
          phase_nxt      = PH_ESCAPE;
        end
        default: begin
          // Escape byte: the command takes effect.
          phase_nxt = PH_HUNT;
          if ((held_speed_r == 8'd0) || (held_position_r == center_position_r)) begin
            duty_nxt = 8'd0;
          end else begin
            if (held_position_r > center_position_r) begin
              dir_nxt              = DIR_CCW;
              intervals_target_nxt = held_position_r - center_position_r;
            end else begin
              dir_nxt              = DIR_CW;
              intervals_target_nxt = center_position_r - held_position_r;
            end
            intervals_done_nxt = 8'd0;
            duty_nxt           = held_speed_r;
            stop_nxt           = 1'b0;
            tick_count_nxt     = 16'd0;
          end
        end
      endcase
    end
  end

  // The result is the state after this transaction.
  assign result = '{duty: duty_nxt, direction: dir_nxt, stopped: stop_nxt};

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= PH_HUNT;
      tick_threshold_r   <= RST_TICK_THRESHOLD;
      center_position_r  <= RST_CENTER_POSITION;
      held_position_r    <= 8'd0;
      held_speed_r       <= 8'd0;
      tick_count_r       <= 16'd0;
      intervals_done_r   <= 8'd0;
      intervals_target_r <= 8'd0;
      stop_r             <= 1'b0;
      duty_r             <= 8'd0;
      dir_r              <= DIR_CCW;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TICK_THRESHOLD:  tick_threshold_r  <= cfg_data;
          CFG_CENTER_POSITION: center_position_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (take) begin
        phase_r            <= phase_nxt;
        held_position_r    <= held_position_nxt;
        held_speed_r       <= held_speed_nxt;
        tick_count_r       <= tick_count_nxt;
        intervals_done_r   <= intervals_done_nxt;
        intervals_target_r <= intervals_target_nxt;
        stop_r             <= stop_nxt;
        duty_r             <= duty_nxt;
        dir_r              <= dir_nxt;
      end
    end
  end

endmodule

FILE: tb/framed_dc_motor_jog_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_dc_motor_jog_controller_test: self-checking bench for the jog block
// Feeds serial bytes and timer ticks through the valid/stall input channel and
// keeps a cycle-free model of the frame parser, run timer and motor drive. It
// checks every result transaction against the model and leaves random gaps and
// stalls on both channels, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module framed_dc_motor_jog_controller_test;
  import fjog_pkg::*;

  // Frame parser phases of the model.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_STEPPER,
    PH_POSITION,
    PH_SPEED,
    PH_ESCAPE
  } frame_phase_e;

  // Register indexes past the end of the register list.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Model state and registers.
  frame_phase_e jog_phase;
  logic [7:0]   jog_position;
  logic [7:0]   jog_speed;
  logic [15:0]  jog_ticks;
  logic [7:0]   jog_done;
  logic [7:0]   jog_target;
  logic         jog_stopped;
  logic [7:0]   jog_duty;
  logic         jog_dir;
  logic [15:0]  jog_threshold;
  logic [7:0]   jog_center;

  // Predicted drive states, oldest first.
  out_t drive_q[$];

  int unsigned fail_count  = 0;
  int unsigned next_gap    = 0;
  int unsigned hold_cycles = 0;
  bit          in_gaps_on  = 1'b1;
  bit          out_gaps_on = 1'b1;

  framed_dc_motor_jog_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Overall time limit.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  function automatic void reset_motor();
    jog_phase     = PH_HUNT;
    jog_position  = '0;
    jog_speed     = '0;
    jog_ticks     = '0;
    jog_done      = '0;
    jog_target    = '0;
    jog_stopped   = 1'b0;
    jog_duty      = '0;
    jog_dir       = DIR_CCW;
    jog_threshold = RST_TICK_THRESHOLD;
    jog_center    = RST_CENTER_POSITION;
  endfunction

  // A finished frame either parks the motor or arms a new timed run.
  function automatic void apply_command();
    if (jog_speed == 8'd0 || jog_position == jog_center) begin
      jog_duty = 8'd0;
    end else begin
      if (jog_position > jog_center) begin
        jog_dir    = DIR_CCW;
        jog_target = jog_position - jog_center;
      end else begin
        jog_dir    = DIR_CW;
        jog_target = jog_center - jog_position;
      end
      jog_done    = 8'd0;
      jog_duty    = jog_speed;
      jog_stopped = 1'b0;
      jog_ticks   = 16'd0;
    end
  endfunction

  // Advances the model by one input transaction and returns the drive state.
  function automatic out_t advance_motor(input in_t item);
    out_t drive;
    if (item.mode == MODE_TICK) begin
      jog_ticks = jog_ticks + 16'd1;
      if (!jog_stopped && jog_ticks > jog_threshold) begin
        jog_ticks = 16'd0;
        if (jog_done < jog_target) begin
          jog_done = jog_done + 8'd1;
        end else begin
          jog_duty    = 8'd0;
          jog_stopped = 1'b1;
        end
      end
    end else begin
      case (jog_phase)
        PH_HUNT: begin
          if (item.data_byte == START_BYTE) jog_phase = PH_STEPPER;
        end
        PH_STEPPER: begin
          jog_phase = PH_POSITION;
        end
        PH_POSITION: begin
          jog_position = item.data_byte;
          jog_phase    = PH_SPEED;
        end
        PH_SPEED: begin
          jog_speed = item.data_byte;
          jog_phase = PH_ESCAPE;
        end
        default: begin
          apply_command();
          jog_phase = PH_HUNT;
        end
      endcase
    end
    drive.duty      = jog_duty;
    drive.direction = jog_dir;
    drive.stopped   = jog_stopped;
    return drive;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one transaction and records its prediction once it is taken. The
  // gap before the next transaction is drawn at acceptance, so valid is
  // lowered only when a gap follows.
  task automatic send_item(input in_t item);
    if (next_gap > 0) repeat (next_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    drive_q.push_back(advance_motor(item));
    next_gap = in_gaps_on ? $urandom_range(0, 6) : 0;
    if (next_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] value);
    in_t item;
    item.mode      = MODE_BYTE;
    item.data_byte = value;
    send_item(item);
  endtask

  // Tick transactions carry random filler in the byte field.
  task automatic send_ticks(input int unsigned count);
    in_t item;
    repeat (count) begin
      item.mode      = MODE_TICK;
      item.data_byte = 8'($urandom_range(0, 255));
      send_item(item);
    end
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic wait_idle();
    if (in_valid && next_gap == 0) in_valid <= 1'b0;
    do @(posedge clk); while (drive_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Writes both registers, then one index past the list that must be ignored.
  task automatic configure(input logic [15:0] threshold, input logic [7:0] center);
    logic [7:0] junk;
    wait_idle();
    junk      = 8'($urandom_range(0, 255));
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TICK_THRESHOLD;
    cfg_data  <= threshold;
    @(posedge clk);
    cfg_index <= CFG_CENTER_POSITION;
    cfg_data  <= {junk, center};
    @(posedge clk);
    cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3;
    cfg_data  <= 16'($urandom_range(0, 65535));
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    jog_threshold = threshold;
    jog_center    = center;
  endtask

  // Mostly positions near centre so that timed runs are short enough to end.
  function automatic logic [7:0] pick_position();
    int lo;
    int hi;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    lo = (jog_center > 4) ? jog_center - 4 : 0;
    hi = (jog_center < 251) ? jog_center + 4 : 255;
    return 8'($urandom_range(lo, hi));
  endfunction

  // Start byte followed by the command bytes, with the odd tick in between.
  // A broken frame stops after a random number of command bytes.
  task automatic send_frame(input bit broken);
    int unsigned body_len;
    logic [7:0]  value;
    body_len = broken ? $urandom_range(0, 3) : 4;
    send_byte(START_BYTE);
    for (int i = 0; i < body_len; i++) begin
      if ($urandom_range(0, 9) == 0) send_ticks(1);
      if (i == 1) value = pick_position();
      else if (i == 2) value = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      else value = 8'($urandom_range(0, 255));
      send_byte(value);
    end
  endtask

  // Random traffic: mostly whole frames followed by tick runs, the rest
  // bare tick runs, line noise and cut-off frames.
  task automatic run_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned roll;
    int unsigned n;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        send_frame(1'b0);
        n = $urandom_range(0, 24);
        send_ticks(n);
        sent += 5 + n;
      end else if (roll < 75) begin
        n = $urandom_range(1, 20);
        send_ticks(n);
        sent += n;
      end else if (roll < 90) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_frame(1'b1);
        sent += 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Draws a stall before every result; a requested hold-off replaces one draw.
  initial begin : result_sink
    int unsigned pause;
    forever begin
      if (hold_cycles > 0) begin
        pause       = hold_cycles;
        hold_cycles = 0;
      end else begin
        pause = out_gaps_on ? $urandom_range(0, 6) : 0;
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin : drive_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        $error("result transaction with nothing predicted: %p", out_data);
        fail_count++;
      end else begin
        want = drive_q.pop_front();
        if (out_data.duty !== want.duty) begin
          $error("duty: expected %0d, actual %0d", want.duty, out_data.duty);
          fail_count++;
        end
        if (out_data.direction !== want.direction) begin
          $error("direction: expected %0d, actual %0d", want.direction, out_data.direction);
          fail_count++;
        end
        if (out_data.stopped !== want.stopped) begin
          $error("stopped: expected %0d, actual %0d", want.stopped, out_data.stopped);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bytes before any start byte are dropped under the reset settings.
  task automatic test_noise_after_reset();
    send_byte(8'h00);
    send_ticks(1);
  endtask

  // The run left by reset has no intervals, so the first interval to end
  // stops the motor; later ticks only count.
  task automatic test_run_from_reset();
    configure(16'd0, RST_CENTER_POSITION);
    send_ticks(2);
  endtask

  // Every byte after a start byte is a frame byte, even another start byte.
  task automatic test_start_byte_in_frame();
    repeat (5) send_byte(START_BYTE);
  endtask

  // Zero speed and a centred position only drop the duty; the run goes on.
  task automatic test_parking_commands();
    send_byte(START_BYTE);
    send_byte(8'h00);
    send_byte(8'd20);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(START_BYTE);
    send_byte(8'h00);
    send_byte(RST_CENTER_POSITION);
    send_byte(8'h40);
    send_byte(8'h00);
  endtask

  // One interval below centre runs clockwise to its end.
  task automatic test_short_run();
    send_byte(START_BYTE);
    send_byte(START_BYTE);
    send_byte(RST_CENTER_POSITION - 8'd1);
    send_byte(8'h01);
    send_byte(8'h00);
    send_ticks(3);
  endtask

  // Random traffic under a range of register settings and idling mixes.
  task automatic test_register_sweep();
    logic [15:0] thresholds[8];
    logic [7:0]  centers[8];
    thresholds = '{16'd0, 16'hFFFF, 16'd1, 16'd2, 16'd0, 16'd3, 16'd20, 16'd0};
    centers    = '{8'd0, 8'd255, 8'd19, 8'd255, 8'd128, 8'd1, 8'd60, 8'd0};
    thresholds[7] = 16'($urandom_range(0, 5));
    centers[7]    = 8'($urandom_range(0, 255));
    foreach (thresholds[i]) begin
      configure(thresholds[i], centers[i]);
      in_gaps_on  = (i % 4) < 2;
      out_gaps_on = (i % 2) == 0;
      run_traffic(190);
    end
    wait_idle();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering back to back, so the output queue fills and the input stalls.
  task automatic test_receiver_holdoff();
    configure(16'd1, RST_CENTER_POSITION);
    in_gaps_on  = 1'b0;
    hold_cycles = 200;
    run_traffic(80);
    wait_idle();
    in_gaps_on = 1'b1;
  endtask

  initial begin
    reset_motor();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_noise_after_reset();
    test_run_from_reset();
    test_start_byte_in_frame();
    test_parking_commands();
    test_short_run();
    test_register_sweep();
    test_receiver_holdoff();

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
